@@ src/bmpdec_pkg.sv @@
`default_nettype none

package bmpdec_pkg;

	localparam int POS_W  = 28;
	localparam int DIM_W  = 25;
	localparam int ADDR_W = 24;
	localparam int ROWB_W = 27;
	localparam int HPOS_W = 6;
	localparam int COLOR_W = 24;

	localparam int MAX_PIXELS   = 16777216;
	localparam int HDR_LEN      = 54;
	localparam int HDR_LAST     = 53;
	localparam int FILE_HDR_LEN = 14;
	localparam int DIB_MIN      = 40;

	localparam logic [15:0] SIG_BM = 16'h4D42;
	localparam logic [15:0] PLANES_ONE = 16'd1;
	localparam logic [15:0] BPP_24 = 16'd24;
	localparam logic [15:0] BPP_32 = 16'd32;
	localparam logic [31:0] COMP_RGB = 32'd0;
	localparam logic [31:0] COMP_BITFIELDS = 32'd3;

	// byte offsets of the captured header fields
	localparam int OFF_SIG    = 0;
	localparam int OFF_OFFSET = 10;
	localparam int OFF_DIB    = 14;
	localparam int OFF_WIDTH  = 18;
	localparam int OFF_HEIGHT = 22;
	localparam int OFF_PLANES = 26;
	localparam int OFF_BPP    = 28;
	localparam int OFF_COMP   = 30;

	// byte lanes within one source pixel
	localparam logic [1:0] LANE_BLUE  = 2'd0;
	localparam logic [1:0] LANE_GREEN = 2'd1;
	localparam logic [1:0] LANE_RED   = 2'd2;
	localparam logic [1:0] LANE_ALPHA = 2'd3;

	typedef logic [POS_W-1:0] pos_t;
	typedef logic [DIM_W-1:0] dim_t;
	typedef logic [ADDR_W-1:0] addr_t;
	typedef logic [ROWB_W-1:0] rowb_t;
	typedef logic [2*DIM_W-1:0] area_t;
	typedef logic [ROWB_W+DIM_W-1:0] span_t;

	typedef enum logic [1:0] {
		KIND_PIXEL  = 2'd0,
		KIND_HEADER = 2'd1,
		KIND_REJECT = 2'd2
	} kind_t;

	typedef enum logic [2:0] {
		ST_OK         = 3'd0,
		ST_SIGNATURE  = 3'd1,
		ST_DIB        = 3'd2,
		ST_FORMAT     = 3'd3,
		ST_DIMENSIONS = 3'd4,
		ST_TOO_LARGE  = 3'd5,
		ST_BOUNDS     = 3'd6
	} status_t;

	typedef struct packed {
		logic              step;
		logic [HPOS_W-1:0] pos;
	} hdr_ctl_t;

	typedef struct packed {
		status_t status;
		dim_t    width;
		dim_t    height;
		pos_t    offset;
		logic    bpb4;
		rowb_t   stride;
		addr_t   base;
		logic    bottom_up;
	} hdr_info_t;

	typedef struct packed {
		kind_t              kind;
		addr_t              address;
		logic [COLOR_W-1:0] color;
		dim_t               width;
		dim_t               height;
		status_t            status;
		logic               last;
	} result_t;

endpackage

`default_nettype wire

@@ src/bmpdec_hdr.sv @@
`default_nettype none

module bmpdec_hdr (
	input wire clk,
	input wire bmpdec_pkg::hdr_ctl_t ctl,
	input wire [7:0] data_byte,
	input wire [bmpdec_pkg::POS_W-1:0] file_size,
	output bmpdec_pkg::hdr_info_t info
);

	logic [15:0] sig_q;
	logic [15:0] planes_q;
	logic [15:0] bpp_q;
	logic [31:0] offset_q;
	logic [31:0] dib_q;
	logic [31:0] width_q;
	logic [31:0] hraw_q;
	logic [31:0] comp_q;

	logic [31:0] habs_q;
	bmpdec_pkg::rowb_t stride_q;
	bmpdec_pkg::area_t area_q;
	bmpdec_pkg::span_t span_q;
	bmpdec_pkg::addr_t hm1_q;
	bmpdec_pkg::addr_t base_q;

	logic bpb4;
	logic [31:0] habs_next;
	bmpdec_pkg::rowb_t wbytes;
	bmpdec_pkg::rowb_t wsum;
	bmpdec_pkg::rowb_t stride_next;
	logic [2*bmpdec_pkg::ADDR_W-1:0] base_full;
	bmpdec_pkg::pos_t room;
	logic sig_bad;
	logic dib_bad;
	logic fmt_bad;
	logic dim_bad;
	logic big_bad;
	logic bnd_bad;
	bmpdec_pkg::status_t status;

	assign bpb4 = (bpp_q == bmpdec_pkg::BPP_32);
	assign habs_next = hraw_q[31] ? (~hraw_q + 32'd1) : hraw_q;

	// row stride in bytes, rounded up to a multiple of four
	assign wbytes = bpb4 ? {width_q[bmpdec_pkg::DIM_W-1:0], 2'b00}
		: ({1'b0, width_q[bmpdec_pkg::DIM_W-1:0], 1'b0}
		+ {2'b00, width_q[bmpdec_pkg::DIM_W-1:0]});
	assign wsum = wbytes + bmpdec_pkg::rowb_t'(3);
	assign stride_next = {wsum[bmpdec_pkg::ROWB_W-1:2], 2'b00};
	assign base_full = hm1_q * width_q[bmpdec_pkg::ADDR_W-1:0];

	// field capture, then the products settle over the later header bytes
	always_ff @(posedge clk) begin
		if (ctl.step) begin
			for (int k = 0; k < 2; k++) begin
				if (int'(ctl.pos) == bmpdec_pkg::OFF_SIG + k) sig_q[k*8 +: 8] <= data_byte;
				if (int'(ctl.pos) == bmpdec_pkg::OFF_PLANES + k) planes_q[k*8 +: 8] <= data_byte;
				if (int'(ctl.pos) == bmpdec_pkg::OFF_BPP + k) bpp_q[k*8 +: 8] <= data_byte;
			end
			for (int k = 0; k < 4; k++) begin
				if (int'(ctl.pos) == bmpdec_pkg::OFF_OFFSET + k) offset_q[k*8 +: 8] <= data_byte;
				if (int'(ctl.pos) == bmpdec_pkg::OFF_DIB + k) dib_q[k*8 +: 8] <= data_byte;
				if (int'(ctl.pos) == bmpdec_pkg::OFF_WIDTH + k) width_q[k*8 +: 8] <= data_byte;
				if (int'(ctl.pos) == bmpdec_pkg::OFF_HEIGHT + k) hraw_q[k*8 +: 8] <= data_byte;
				if (int'(ctl.pos) == bmpdec_pkg::OFF_COMP + k) comp_q[k*8 +: 8] <= data_byte;
			end
			habs_q <= habs_next;
			stride_q <= stride_next;
			area_q <= width_q[bmpdec_pkg::DIM_W-1:0] * habs_q[bmpdec_pkg::DIM_W-1:0];
			span_q <= stride_q * habs_q[bmpdec_pkg::DIM_W-1:0];
			hm1_q <= habs_q[bmpdec_pkg::ADDR_W-1:0] - bmpdec_pkg::addr_t'(1);
			base_q <= base_full[bmpdec_pkg::ADDR_W-1:0];
		end
	end

	always_comb begin
		room = file_size - offset_q[bmpdec_pkg::POS_W-1:0];
		sig_bad = (sig_q != bmpdec_pkg::SIG_BM);
		dib_bad = (dib_q < 32'(bmpdec_pkg::DIB_MIN))
			|| (({1'b0, dib_q} + 33'(bmpdec_pkg::FILE_HDR_LEN)) > {5'b0, file_size});
		fmt_bad = (planes_q != bmpdec_pkg::PLANES_ONE)
			|| ((bpp_q != bmpdec_pkg::BPP_24) && !bpb4)
			|| ((comp_q != bmpdec_pkg::COMP_RGB)
			&& !((comp_q == bmpdec_pkg::COMP_BITFIELDS) && bpb4));
		dim_bad = (width_q == 32'd0) || width_q[31] || (habs_q == 32'd0) || habs_q[31];
		// either side past the product limit already overflows it
		big_bad = (|width_q[30:bmpdec_pkg::DIM_W]) || (|habs_q[30:bmpdec_pkg::DIM_W])
			|| (area_q > bmpdec_pkg::area_t'(bmpdec_pkg::MAX_PIXELS));
		bnd_bad = (offset_q > {4'b0, file_size})
			|| (span_q > bmpdec_pkg::span_t'(room))
			|| (offset_q < 32'(bmpdec_pkg::HDR_LEN));
		if (sig_bad) status = bmpdec_pkg::ST_SIGNATURE;
		else if (dib_bad) status = bmpdec_pkg::ST_DIB;
		else if (fmt_bad) status = bmpdec_pkg::ST_FORMAT;
		else if (dim_bad) status = bmpdec_pkg::ST_DIMENSIONS;
		else if (big_bad) status = bmpdec_pkg::ST_TOO_LARGE;
		else if (bnd_bad) status = bmpdec_pkg::ST_BOUNDS;
		else status = bmpdec_pkg::ST_OK;
	end

	always_comb begin
		info.status = status;
		info.width = width_q[bmpdec_pkg::DIM_W-1:0];
		info.height = habs_q[bmpdec_pkg::DIM_W-1:0];
		info.offset = offset_q[bmpdec_pkg::POS_W-1:0];
		info.bpb4 = bpb4;
		info.stride = stride_q;
		info.base = base_q;
		info.bottom_up = !hraw_q[31];
	end

endmodule

`default_nettype wire

@@ src/bmpdec_ctrl.sv @@
`default_nettype none

module bmpdec_ctrl (
	input wire clk,
	input wire arst_n,
	input wire step,
	input wire first_byte,
	input wire [7:0] data_byte,
	input wire [bmpdec_pkg::POS_W-1:0] file_size,
	input wire bmpdec_pkg::hdr_info_t info,
	output bmpdec_pkg::hdr_ctl_t hdr_ctl,
	output logic emit,
	output bmpdec_pkg::result_t result
);

	typedef enum logic [1:0] {
		PH_HEADER,
		PH_PIXELS,
		PH_IDLE
	} phase_t;

	phase_t phase_q, phase_d, eff_phase;
	bmpdec_pkg::pos_t pos_q, pos_d, eff_pos;
	bmpdec_pkg::dim_t col_q, col_d, col_inc;
	bmpdec_pkg::dim_t rows_q, rows_d, rows_inc;
	bmpdec_pkg::rowb_t rbc_q, rbc_d, rbc_inc;
	bmpdec_pkg::addr_t base_q, base_d;
	logic [1:0] sub_q, sub_d, sub_last;
	logic [15:0] pp_q, pp_d;

	always_comb begin
		eff_phase = first_byte ? PH_HEADER : phase_q;
		eff_pos = first_byte ? '0 : pos_q;
		hdr_ctl.step = step && (eff_phase == PH_HEADER);
		hdr_ctl.pos = eff_pos[bmpdec_pkg::HPOS_W-1:0];
	end

	always_comb begin
		phase_d = phase_q;
		pos_d = pos_q;
		col_d = col_q;
		rows_d = rows_q;
		rbc_d = rbc_q;
		base_d = base_q;
		sub_d = sub_q;
		pp_d = pp_q;
		emit = 1'b0;
		result = '0;
		col_inc = col_q + bmpdec_pkg::dim_t'(1);
		rows_inc = rows_q + bmpdec_pkg::dim_t'(1);
		rbc_inc = rbc_q + bmpdec_pkg::rowb_t'(1);
		sub_last = info.bpb4 ? bmpdec_pkg::LANE_ALPHA : bmpdec_pkg::LANE_RED;
		unique case (eff_phase)
			PH_HEADER: begin
				phase_d = PH_HEADER;
				pos_d = eff_pos + bmpdec_pkg::pos_t'(1);
				if ((eff_pos == '0) && (file_size < bmpdec_pkg::pos_t'(bmpdec_pkg::HDR_LEN))) begin
					phase_d = PH_IDLE;
					emit = 1'b1;
					result.kind = bmpdec_pkg::KIND_REJECT;
					result.status = bmpdec_pkg::ST_SIGNATURE;
					result.last = 1'b1;
				end else if (eff_pos == bmpdec_pkg::pos_t'(bmpdec_pkg::HDR_LAST)) begin
					emit = 1'b1;
					if (info.status != bmpdec_pkg::ST_OK) begin
						phase_d = PH_IDLE;
						result.kind = bmpdec_pkg::KIND_REJECT;
						result.status = info.status;
						result.last = 1'b1;
					end else begin
						phase_d = PH_PIXELS;
						pos_d = bmpdec_pkg::pos_t'(bmpdec_pkg::HDR_LEN);
						col_d = '0;
						rows_d = '0;
						rbc_d = '0;
						sub_d = bmpdec_pkg::LANE_BLUE;
						pp_d = '0;
						// bottom-up files start at the last frame row
						base_d = info.bottom_up ? info.base : '0;
						result.kind = bmpdec_pkg::KIND_HEADER;
						result.width = info.width;
						result.height = info.height;
					end
				end
			end
			PH_PIXELS: begin
				pos_d = pos_q + bmpdec_pkg::pos_t'(1);
				if (pos_q >= info.offset) begin
					if (col_q < info.width) begin
						case (sub_q)
							bmpdec_pkg::LANE_BLUE: pp_d = {8'h00, data_byte};
							bmpdec_pkg::LANE_GREEN: pp_d = {data_byte, pp_q[7:0]};
							bmpdec_pkg::LANE_RED: begin
								emit = 1'b1;
								result.kind = bmpdec_pkg::KIND_PIXEL;
								result.address = base_q + col_q[bmpdec_pkg::ADDR_W-1:0];
								result.color = {data_byte, pp_q};
								result.last = (col_inc == info.width) && (rows_inc == info.height);
							end
							default: ;
						endcase
						if (sub_q == sub_last) begin
							col_d = col_inc;
							sub_d = bmpdec_pkg::LANE_BLUE;
						end else begin
							sub_d = sub_q + 2'd1;
						end
					end
					rbc_d = rbc_inc;
					// end of row, padding included
					if (rbc_inc >= info.stride) begin
						rbc_d = '0;
						col_d = '0;
						sub_d = bmpdec_pkg::LANE_BLUE;
						rows_d = rows_inc;
						if (info.bottom_up) base_d = base_q - info.width[bmpdec_pkg::ADDR_W-1:0];
						else base_d = base_q + info.width[bmpdec_pkg::ADDR_W-1:0];
						if (rows_inc >= info.height) phase_d = PH_IDLE;
					end
				end
			end
			PH_IDLE: ;
			default: phase_d = PH_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HEADER;
			pos_q <= '0;
			col_q <= '0;
			rows_q <= '0;
			rbc_q <= '0;
			base_q <= '0;
			sub_q <= bmpdec_pkg::LANE_BLUE;
			pp_q <= '0;
		end else if (step) begin
			phase_q <= phase_d;
			pos_q <= pos_d;
			col_q <= col_d;
			rows_q <= rows_d;
			rbc_q <= rbc_d;
			base_q <= base_d;
			sub_q <= sub_d;
			pp_q <= pp_d;
		end
	end

endmodule

`default_nettype wire

@@ src/bmp_stream_decoder_core.sv @@
// channel  dir  payload                                   taken when
// cfg      in   file_size                                 cfg_valid & cfg_ready
// byte     in   first_byte, data_byte                     byte_valid & byte_ready
// result   out  kind, pixel_address, pixel_color,         result_valid & result_ready
//               image_width, image_height, status, last
//
// one byte per cycle unless stalled; a byte passes the input register, then the result register
// each byte is parsed combinationally between the input register and the result register
// header products are built over header bytes 26 to 31, so the check at byte 53 is one compare
// a full result register that is not taken holds back only a byte that makes a result
// reset sets file_size to zero and parsing to the header phase; no clearing pass
`default_nettype none

module bmp_stream_decoder_core (
	input wire clk,
	input wire arst_n,
	input wire cfg_valid,
	output logic cfg_ready,
	input wire [bmpdec_pkg::POS_W-1:0] file_size,
	input wire byte_valid,
	output logic byte_ready,
	input wire first_byte,
	input wire [7:0] data_byte,
	output logic result_valid,
	input wire result_ready,
	output logic [1:0] kind,
	output logic [bmpdec_pkg::ADDR_W-1:0] pixel_address,
	output logic [bmpdec_pkg::COLOR_W-1:0] pixel_color,
	output logic [bmpdec_pkg::DIM_W-1:0] image_width,
	output logic [bmpdec_pkg::DIM_W-1:0] image_height,
	output logic [2:0] status,
	output logic last
);

	bmpdec_pkg::pos_t file_size_q;
	logic s1_valid;
	logic first_s1;
	logic [7:0] byte_s1;
	logic res_valid_q;
	bmpdec_pkg::result_t res_q;

	logic step;
	logic emit;
	bmpdec_pkg::result_t res_next;
	bmpdec_pkg::hdr_ctl_t hdr_ctl;
	bmpdec_pkg::hdr_info_t hdr_info;

	assign cfg_ready = 1'b1;
	assign step = s1_valid && (!emit || !res_valid_q || result_ready);
	assign byte_ready = !s1_valid || step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			file_size_q <= '0;
		end else if (cfg_valid) begin
			file_size_q <= file_size;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (byte_ready) s1_valid <= byte_valid;
			if (step && emit) res_valid_q <= 1'b1;
			else if (result_ready) res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_valid && byte_ready) begin
			first_s1 <= first_byte;
			byte_s1 <= data_byte;
		end
		if (step && emit) res_q <= res_next;
	end

	bmpdec_hdr u_hdr (
		.clk(clk),
		.ctl(hdr_ctl),
		.data_byte(byte_s1),
		.file_size(file_size_q),
		.info(hdr_info)
	);

	bmpdec_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.step(step),
		.first_byte(first_s1),
		.data_byte(byte_s1),
		.file_size(file_size_q),
		.info(hdr_info),
		.hdr_ctl(hdr_ctl),
		.emit(emit),
		.result(res_next)
	);

	assign result_valid = res_valid_q;
	assign kind = res_q.kind;
	assign pixel_address = res_q.address;
	assign pixel_color = res_q.color;
	assign image_width = res_q.width;
	assign image_height = res_q.height;
	assign status = res_q.status;
	assign last = res_q.last;

endmodule

`default_nettype wire

@@ src/bmpdec_checker.sv @@
`default_nettype none

module bmpdec_checker (
	input wire clk,
	input wire arst_n,
	input wire result_valid,
	input wire result_ready,
	input wire [1:0] kind,
	input wire [bmpdec_pkg::ADDR_W-1:0] pixel_address,
	input wire [bmpdec_pkg::COLOR_W-1:0] pixel_color,
	input wire [bmpdec_pkg::DIM_W-1:0] image_width,
	input wire [bmpdec_pkg::DIM_W-1:0] image_height,
	input wire [2:0] status,
	input wire last
);

	// a stalled result item holds its kind, address, color, status and last
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(kind)
		&& $stable(pixel_address) && $stable(pixel_color) && $stable(status) && $stable(last))
		else $error("result item changed while stalled");

	a_reject_fields: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (kind == bmpdec_pkg::KIND_REJECT) |->
		last && (status != bmpdec_pkg::ST_OK) && (image_width == '0) && (image_height == '0))
		else $error("rejection without last or status");

	a_header_fields: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (kind == bmpdec_pkg::KIND_HEADER) |->
		!last && (status == bmpdec_pkg::ST_OK) && (image_width != '0) && (image_height != '0))
		else $error("header result with bad fields");

	a_pixel_fields: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (kind == bmpdec_pkg::KIND_PIXEL) |->
		(status == bmpdec_pkg::ST_OK) && (image_width == '0) && (image_height == '0))
		else $error("pixel result with header fields set");

endmodule

bind bmp_stream_decoder_core bmpdec_checker u_checker (.*);

`default_nettype wire
